[design/esd_pkg.sv]
// ============================================================================
// esd_pkg
// Shared types, constants and a helper function of the escape sequence decoder.
// ============================================================================
package esd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] ADDR_ESCAPE_ENABLE  = 3'd0;
    localparam logic [2:0] ADDR_NEWLINE_ENABLE = 3'd4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;

    localparam logic [7:0] LT_E    = 8'h65;
    localparam logic [7:0] LT_A    = 8'h61;
    localparam logic [7:0] LT_T    = 8'h74;
    localparam logic [7:0] LT_B    = 8'h62;
    localparam logic [7:0] LT_R    = 8'h72;
    localparam logic [7:0] LT_N    = 8'h6E;
    localparam logic [7:0] LT_V    = 8'h76;
    localparam logic [7:0] LT_F    = 8'h66;
    localparam logic [7:0] LT_X    = 8'h78;
    localparam logic [7:0] LT_ZERO = 8'h30;

    localparam logic [1:0] HEX_DIGITS = 2'd2;
    localparam logic [1:0] OCT_DIGITS = 2'd3;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_BSLASH,
        MODE_HEX,
        MODE_OCT
    } t_mode;

    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } t_bundle;

    // Returns {valid, digit} for a hex digit or, with is_hex low, an octal digit.
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic is_hex);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h37) begin
            res = {1'b1, 1'b0, c[2:0]};
        end else if (is_hex && (c == 8'h38 || c == 8'h39)) begin
            res = {1'b1, c[3:0]};
        end else if (is_hex && ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))) begin
            res = {1'b1, 1'b1, c[2:0] + 3'd1};
        end
        return res;
    endfunction

endpackage

[design/esd_front.sv]
// ============================================================================
// esd_front
// Accepts argument bytes, tracks the escape parse state and turns each byte
// into a bundle of up to three output bytes for the queue.
// ============================================================================
module esd_front
    import esd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_escape_enable,
    input  logic    i_newline_enable,
    input  logic    i_valid,
    input  logic    i_queue_full,
    input  logic    [7:0] i_char_code,
    input  logic    i_arg_end,
    input  logic    i_final_arg,
    output logic    o_ready,
    output logic    o_push,
    output t_bundle o_bundle
);

    t_mode      r_mode, n_mode;
    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_val, n_val;

    logic [1:0]      e_n;
    logic [2:0][7:0] e_bytes;
    logic [4:0]      dig;
    logic [1:0]      maxd;
    logic            accept;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_val   = r_val;
        e_n     = 2'd0;
        e_bytes = '0;
        dig     = digit_of(i_char_code, r_mode == MODE_HEX);
        maxd    = (r_mode == MODE_HEX) ? HEX_DIGITS : OCT_DIGITS;

        if (!i_escape_enable) begin
            n_mode = MODE_NORMAL;
            n_cnt  = 2'd0;
            n_val  = 8'd0;
            e_bytes[e_n] = i_char_code;
            e_n = e_n + 2'd1;
        end else begin
            unique case (r_mode)
                MODE_NORMAL: begin
                    if (i_char_code == CH_BSLASH && !i_arg_end) begin
                        n_mode = MODE_BSLASH;
                    end else begin
                        e_bytes[e_n] = i_char_code;
                        e_n = e_n + 2'd1;
                    end
                end
                MODE_BSLASH: begin
                    n_mode = MODE_NORMAL;
                    case (i_char_code)
                        LT_E: begin e_bytes[e_n] = CH_ESC; e_n = e_n + 2'd1; end
                        LT_A: begin e_bytes[e_n] = CH_BEL; e_n = e_n + 2'd1; end
                        LT_T: begin e_bytes[e_n] = CH_TAB; e_n = e_n + 2'd1; end
                        LT_B: begin e_bytes[e_n] = CH_BS; e_n = e_n + 2'd1; end
                        LT_R: begin e_bytes[e_n] = CH_CR; e_n = e_n + 2'd1; end
                        LT_N: begin e_bytes[e_n] = CH_LF; e_n = e_n + 2'd1; end
                        LT_V: begin e_bytes[e_n] = CH_VT; e_n = e_n + 2'd1; end
                        LT_F: begin e_bytes[e_n] = CH_FF; e_n = e_n + 2'd1; end
                        CH_BSLASH: begin e_bytes[e_n] = CH_BSLASH; e_n = e_n + 2'd1; end
                        LT_X: begin
                            n_mode = MODE_HEX;
                            n_cnt  = 2'd0;
                            n_val  = 8'd0;
                        end
                        LT_ZERO: begin
                            n_mode = MODE_OCT;
                            n_cnt  = 2'd0;
                            n_val  = 8'd0;
                        end
                        default: begin
                            e_bytes[e_n] = CH_BSLASH;
                            e_n = e_n + 2'd1;
                            e_bytes[e_n] = i_char_code;
                            e_n = e_n + 2'd1;
                        end
                    endcase
                end
                MODE_HEX, MODE_OCT: begin
                    if (dig[4]) begin
                        n_val = (r_mode == MODE_HEX) ? {r_val[3:0], dig[3:0]}
                                                     : {r_val[4:0], dig[2:0]};
                        n_cnt = r_cnt + 2'd1;
                        if (n_cnt >= maxd) begin
                            e_bytes[e_n] = n_val;
                            e_n = e_n + 2'd1;
                            n_mode = MODE_NORMAL;
                            n_cnt  = 2'd0;
                            n_val  = 8'd0;
                        end
                    end else begin
                        e_bytes[e_n] = r_val;
                        e_n = e_n + 2'd1;
                        n_mode = MODE_NORMAL;
                        n_cnt  = 2'd0;
                        n_val  = 8'd0;
                        if (i_char_code == CH_BSLASH && !i_arg_end) begin
                            n_mode = MODE_BSLASH;
                        end else begin
                            e_bytes[e_n] = i_char_code;
                            e_n = e_n + 2'd1;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_NORMAL;
                end
            endcase
        end

        if (i_arg_end) begin
            if (n_mode == MODE_HEX || n_mode == MODE_OCT) begin
                e_bytes[e_n] = n_val;
                e_n = e_n + 2'd1;
            end
            n_mode = MODE_NORMAL;
            n_cnt  = 2'd0;
            n_val  = 8'd0;
            if (!i_final_arg) begin
                e_bytes[e_n] = CH_SPACE;
                e_n = e_n + 2'd1;
            end else if (i_newline_enable) begin
                e_bytes[e_n] = CH_LF;
                e_n = e_n + 2'd1;
            end
        end
    end

    assign o_push         = accept && (e_n != 2'd0);
    assign o_bundle.count = e_n;
    assign o_bundle.bytes = e_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cnt  <= 2'd0;
            r_val  <= 8'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_val  <= n_val;
        end
    end

endmodule

[design/esd_queue.sv]
// ============================================================================
// esd_queue
// Short queue of decoded byte bundles between the front and the back part.
// ============================================================================
module esd_queue
    import esd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_bundle o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push && !o_full) - CW'(do_pop);
        end
    end

endmodule

[design/esd_back.sv]
// ============================================================================
// esd_back
// Streams the bytes of the head bundle one per transaction and marks the
// last byte of each bundle.
// ============================================================================
module esd_back
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_bundle    i_head,
    input  logic       i_ready,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic [1:0] r_idx;
    logic       take;

    assign o_valid    = !i_empty;
    assign o_out_byte = i_head.bytes[r_idx];
    assign o_run_last = (r_idx == i_head.count - 2'd1);
    assign take       = o_valid && i_ready;
    assign o_pop      = take && o_run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= o_run_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

[design/escape_sequence_decoder_unit.sv]
// ============================================================================
// escape_sequence_decoder_unit
// Decodes backslash escapes of echo arguments into an output byte stream.
// ============================================================================
//  Channel   Direction  Transaction carries
//  s_axis    in         tdata = char_code, tlast = arg_end, tuser = final_arg
//  m_axis    out        tdata = out_byte, tlast = run_last
//  APB       in         0x0 escape_enable, 0x4 newline_enable
//
// The front part takes one byte per cycle while the queue has room.
// Each byte yields zero to three output bytes; the back part sends one per cycle while m_axis_tready is high.
// A byte that yields one output byte therefore sustains one transaction per cycle.
// Reset is synchronous and empties the queue; no output is valid after it.
// A stalled output fills the queue, and only then is s_axis_tready dropped.
module escape_sequence_decoder_unit
    import esd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // [0] final_arg
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    r_escape_enable;
    logic    r_newline_enable;
    logic    push, pop, full, empty;
    t_bundle bundle, head;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_enable  <= 1'b0;
            r_newline_enable <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_NEWLINE_ENABLE[2]) begin
                r_newline_enable <= pwdata[0];
            end else begin
                r_escape_enable <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ADDR_NEWLINE_ENABLE[2]) begin
            prdata[0] = r_newline_enable;
        end else begin
            prdata[0] = r_escape_enable;
        end
    end

    esd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_escape_enable  (r_escape_enable),
        .i_newline_enable (r_newline_enable),
        .i_valid          (s_axis_tvalid),
        .i_queue_full     (full),
        .i_char_code      (s_axis_tdata),
        .i_arg_end        (s_axis_tlast),
        .i_final_arg      (s_axis_tuser),
        .o_ready          (s_axis_tready),
        .o_push           (push),
        .o_bundle         (bundle)
    );

    esd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (bundle),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    esd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .i_ready    (m_axis_tready),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .o_out_byte (m_axis_tdata),
        .o_run_last (m_axis_tlast)
    );

endmodule

[design/esd_checker.sv]
// ============================================================================
// esd_checker
// Port-level checks of the escape sequence decoder, bound to the top level.
// ============================================================================
module esd_checker
    import esd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [2:0]  paddr,
    input logic [31:0] prdata
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    a_copy_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !m_axis_tvalid && paddr == ADDR_ESCAPE_ENABLE && !prdata[0] |=>
            m_axis_tvalid && m_axis_tdata == $past(s_axis_tdata))
        else $error("byte not copied with escapes disabled");

    a_arg_end_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_axis_tlast && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("argument end produced no output");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled while output is idle");

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .paddr         (paddr),
    .prdata        (prdata)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the echo escape sequence decoder. Argument bytes are
// streamed in with random gaps, decoded bytes are drained with random stalls,
// and every output transaction is compared against a behavioral prediction.
// ============================================================================
module tb_top
    import esd_pkg::*;
;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_DELAY = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 86;

    class echo_scoreboard;
        t_mode      mode;
        logic [1:0] ndig;
        logic [7:0] acc;
        bit         esc_en;
        bit         nl_en;
        logic [8:0] expected_q[$];
        logic [7:0] produced[$];
        int         accepted;
        int         results;
        int         mismatches;

        function new();
            clear_parse();
            esc_en = 1'b0;
            nl_en  = 1'b1;
        endfunction

        function void clear_parse();
            mode = MODE_NORMAL;
            ndig = 2'd0;
            acc  = 8'd0;
        endfunction

        function void set_reg(logic [2:0] addr, bit value);
            case (addr)
                ADDR_ESCAPE_ENABLE:  esc_en = value;
                ADDR_NEWLINE_ENABLE: nl_en  = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void emit(logic [7:0] b);
            if (produced.size() < 3) produced.push_back(b);
        endfunction

        function int digit_in_base(logic [7:0] c, int base);
            int d;
            d = -1;
            if (c >= "0" && c <= "9") d = c - "0";
            else if (c >= "a" && c <= "f") d = c - "a" + 10;
            else if (c >= "A" && c <= "F") d = c - "A" + 10;
            if (d >= base) d = -1;
            return d;
        endfunction

        function void plain_byte(logic [7:0] c, bit at_end);
            if (c == CH_BSLASH && !at_end) mode = MODE_BSLASH;
            else emit(c);
        endfunction

        function void note_input(logic [7:0] c, bit at_end, bit fin);
            int         d;
            int         base;
            int         tmp;
            logic [1:0] maxd;
            produced.delete();
            accepted++;
            if (!esc_en) begin
                clear_parse();
                emit(c);
            end else if (mode == MODE_NORMAL) begin
                plain_byte(c, at_end);
            end else if (mode == MODE_BSLASH) begin
                mode = MODE_NORMAL;
                case (c)
                    LT_E:      emit(CH_ESC);
                    LT_A:      emit(CH_BEL);
                    LT_T:      emit(CH_TAB);
                    LT_B:      emit(CH_BS);
                    LT_R:      emit(CH_CR);
                    LT_N:      emit(CH_LF);
                    LT_V:      emit(CH_VT);
                    LT_F:      emit(CH_FF);
                    CH_BSLASH: emit(CH_BSLASH);
                    LT_X: begin
                        mode = MODE_HEX;
                        ndig = 2'd0;
                        acc  = 8'd0;
                    end
                    LT_ZERO: begin
                        mode = MODE_OCT;
                        ndig = 2'd0;
                        acc  = 8'd0;
                    end
                    default: begin
                        emit(CH_BSLASH);
                        emit(c);
                    end
                endcase
            end else begin
                base = (mode == MODE_HEX) ? 16 : 8;
                maxd = (mode == MODE_HEX) ? HEX_DIGITS : OCT_DIGITS;
                d = digit_in_base(c, base);
                if (d >= 0) begin
                    tmp  = acc * base + d;
                    acc  = tmp[7:0];
                    ndig = ndig + 2'd1;
                    if (ndig >= maxd) begin
                        emit(acc);
                        clear_parse();
                    end
                end else begin
                    emit(acc);
                    clear_parse();
                    plain_byte(c, at_end);
                end
            end
            if (at_end) begin
                if (mode == MODE_HEX || mode == MODE_OCT) emit(acc);
                clear_parse();
                if (!fin) emit(CH_SPACE);
                else if (nl_en) emit(CH_LF);
            end
            foreach (produced[i]) begin
                expected_q.push_back({i == produced.size() - 1, produced[i]});
            end
        endfunction

        function void note_error(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check_result(logic [7:0] b, logic last);
            logic [8:0] e;
            results++;
            if (expected_q.size() == 0) begin
                note_error($sformatf("unexpected byte %02h last %b", b, last));
                return;
            end
            e = expected_q.pop_front();
            if (b !== e[7:0])
                note_error($sformatf("out_byte expected %02h actual %02h", e[7:0], b));
            if (last !== e[8])
                note_error($sformatf("run_last expected %b actual %b", e[8], last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_code
    logic        s_axis_tlast;
    logic        s_axis_tuser;   // [0] final_arg
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    echo_scoreboard sb = new();
    logic [7:0]     arg_bytes[$];
    bit             src_burst;
    bit             hold_sink;
    int             cycles;
    int             settings;

    escape_sequence_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout with %0d bytes still expected.", sb.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Inputs are noted before outputs so a same-edge transaction pair stays ordered.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tlast, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        int  stall;
        int  run_left;
        bit  quiet;
        m_axis_tready <= 1'b0;
        run_left = 0;
        quiet    = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (run_left == 0) begin
                run_left = $urandom_range(5, 30);
                quiet    = ($urandom_range(0, 2) == 0);
            end
            run_left--;
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (hold_sink) begin
                stall     = HOLD_CYCLES;
                hold_sink = 1'b0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_item(logic [7:0] c, bit at_end, bit fin);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= at_end;
        s_axis_tuser  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_arg(string s, bit fin);
        for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1, fin);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(addr, value[0]);
        @(posedge i_clk);
    endtask

    task automatic configure(bit esc, bit nl);
        apb_write(ADDR_ESCAPE_ENABLE, {31'd0, esc});
        apb_write(ADDR_NEWLINE_ENABLE, {31'd0, nl});
        settings++;
    endtask

    // A byte that starts an escape yields nothing, so allow the pipeline to drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_DELAY) @(posedge i_clk);
    endtask

    function automatic void make_token();
        string      letters = "eatbrnvf\\";
        string      hexset  = "0123456789abcdefABCDEF";
        string      octset  = "01234567";
        int         n;
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                arg_bytes.push_back(c == CH_BSLASH ? LT_A : c);
            end
            3, 4: begin
                arg_bytes.push_back(CH_BSLASH);
                arg_bytes.push_back(letters[$urandom_range(0, letters.len() - 1)]);
            end
            5: begin
                arg_bytes.push_back(CH_BSLASH);
                arg_bytes.push_back(LT_X);
                n = $urandom_range(0, 3);
                repeat (n) arg_bytes.push_back(hexset[$urandom_range(0, 21)]);
            end
            6: begin
                arg_bytes.push_back(CH_BSLASH);
                arg_bytes.push_back(LT_ZERO);
                n = $urandom_range(0, 4);
                repeat (n) arg_bytes.push_back(octset[$urandom_range(0, 7)]);
            end
            7: begin
                arg_bytes.push_back(CH_BSLASH);
                arg_bytes.push_back(8'($urandom_range(1, 255)));
            end
            default: arg_bytes.push_back(8'($urandom_range(1, 255)));
        endcase
    endfunction

    task automatic run_phase(bit esc, bit nl, bit with_hold);
        int  sent;
        int  ntok;
        bit  fin;
        sent = 0;
        configure(esc, nl);
        if (with_hold) hold_sink = 1'b1;
        while (sent < PHASE_ITEMS) begin
            arg_bytes.delete();
            ntok = $urandom_range(1, 4);
            repeat (ntok) make_token();
            fin       = ($urandom_range(0, 3) == 0);
            src_burst = with_hold || ($urandom_range(0, 3) == 0);
            foreach (arg_bytes[i]) send_item(arg_bytes[i], i == arg_bytes.size() - 1, fin);
            sent += arg_bytes.size();
        end
        settle();
    endtask

    initial begin
        cycles        = 0;
        settings      = 0;
        hold_sink     = 1'b0;
        src_burst     = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 3'd0;
        pwdata        <= 32'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(1'b1, 1'b1);
        send_arg("\\e", 1'b0);
        send_arg("\\x4g", 1'b0);
        send_arg("\\0777", 1'b0);
        send_arg("\\q", 1'b0);
        send_arg("a\\x", 1'b0);
        send_arg("\\x5\\", 1'b0);
        send_item(8'h01, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        // Leave a hex escape open so the next setting drops it.
        send_item(CH_BSLASH, 1'b0, 1'b0);
        send_item(LT_X, 1'b0, 1'b0);
        send_item("4", 1'b0, 1'b0);
        settle();

        run_phase(1'b0, 1'b1, 1'b0);
        run_phase(1'b1, 1'b0, 1'b1);
        run_phase(1'b0, 1'b0, 1'b0);
        run_phase(1'b1, 1'b1, 1'b0);

        $display("Streamed %0d argument bytes and checked %0d decoded bytes.",
                 sb.accepted, sb.results);
        $display("Register settings applied: %0d; mismatches: %0d.",
                 settings, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
